// ===== src/cfan_pkg.sv =====
// ----------------------------------------------------------------------------
// cfan_pkg
// Shared constants for the custom float adder with normalization.
// ----------------------------------------------------------------------------
package cfan_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned HalfW    = 16;
    localparam int unsigned ShiftW   = 4;
    localparam int unsigned AddrW    = 3;

    localparam logic [HalfW-1:0]  GapLimit     = 16'd11;
    localparam int unsigned       SignPos      = 15;
    localparam int unsigned       OvfPos       = 13;
    localparam int unsigned       NormPos      = 12;
    localparam int unsigned       MaxLeftSteps = 13;
    localparam logic [WordW-1:0]  ClearLsb     = 32'hFFFF_FFFE;

    localparam logic [0:0] RegZeroCode = 1'b0;

endpackage

// ===== src/custom_float_adder_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// custom_float_adder_normalize_unit
// Adds two custom floats (16-bit exponent, 16-bit signed mantissa) and
// renormalizes the sum through a four-stage pipeline.
// Throughput: one request per cycle; each stage holds only while full and
// blocked downstream.
// Reset: synchronous active-low aresetn clears all valid bits and zero_code.
// ----------------------------------------------------------------------------
module custom_float_adder_normalize_unit
    import cfan_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrW-1:0]     paddr,
    input  logic [WordW-1:0]     pwdata,
    output logic [WordW-1:0]     prdata,
    output logic                 pready,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WordW-1:0]     s_operand_a,
    input  logic [WordW-1:0]     s_operand_b,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WordW-1:0]     m_sum
);

    logic [WordW-1:0] zero_code_reg;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_code_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[AddrW-1] == RegZeroCode)) begin
            zero_code_reg <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[AddrW-1] == RegZeroCode) begin
            prdata = zero_code_reg;
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: order operands, compute gap
    logic [WordW-1:0]  big_next, small_next;
    logic [HalfW-1:0]  gap_full;
    logic              bypass1_next;
    logic [WordW-1:0]  big1_reg;
    logic [HalfW-1:0]  small1_reg;
    logic [ShiftW-1:0] gap1_reg;
    logic              bypass1_reg, same1_reg;

    always_comb begin
        if ($signed(s_operand_b) > $signed(s_operand_a)) begin
            big_next   = s_operand_b;
            small_next = s_operand_a;
        end else begin
            big_next   = s_operand_a;
            small_next = s_operand_b;
        end
        gap_full     = big_next[WordW-1:HalfW] - small_next[WordW-1:HalfW];
        bypass1_next = gap_full[SignPos] || (gap_full > GapLimit);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            big1_reg    <= big_next;
            small1_reg  <= small_next[HalfW-1:0];
            gap1_reg    <= gap_full[ShiftW-1:0];
            bypass1_reg <= bypass1_next;
            same1_reg   <= (s_operand_a[SignPos] == s_operand_b[SignPos]);
        end
    end

    // stage 2: align and add
    logic [HalfW-1:0] aligned;
    logic [HalfW-1:0] man2_next;
    logic [HalfW-1:0] exp2_reg, man2_reg;
    logic             bypass2_reg, same2_reg;

    always_comb begin
        aligned = $signed(small1_reg) >>> gap1_reg;
        if (bypass1_reg) begin
            man2_next = big1_reg[HalfW-1:0];
        end else begin
            man2_next = big1_reg[HalfW-1:0] + aligned;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            exp2_reg    <= big1_reg[WordW-1:HalfW];
            man2_reg    <= man2_next;
            bypass2_reg <= bypass1_reg;
            same2_reg   <= same1_reg;
        end
    end

    // stage 3: classify sum, count leading sign copies from the norm bit down
    logic [ShiftW-1:0] lead_next;
    logic              lead_run;
    logic [HalfW-1:0]  exp3_reg, man3_reg;
    logic [ShiftW-1:0] lead3_reg;
    logic              bypass3_reg, same3_reg, zero3_reg;

    always_comb begin
        lead_next = '0;
        lead_run  = 1'b1;
        for (int i = 0; i < MaxLeftSteps; i++) begin
            if (lead_run && (man2_reg[NormPos-i] == man2_reg[SignPos])) begin
                lead_next = lead_next + ShiftW'(1);
            end else begin
                lead_run = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            exp3_reg    <= exp2_reg;
            man3_reg    <= man2_reg;
            lead3_reg   <= lead_next;
            bypass3_reg <= bypass2_reg;
            same3_reg   <= same2_reg;
            zero3_reg   <= (man2_reg == '0);
        end
    end

    // stage 4: normalize into the output register
    logic [WordW-1:0] sum_next;
    logic [WordW-1:0] sum4_reg;
    logic [HalfW-1:0] man_asr1;

    always_comb begin
        man_asr1 = $signed(man3_reg) >>> 1;
        if (bypass3_reg) begin
            sum_next = {exp3_reg, man3_reg};
        end else if (zero3_reg) begin
            sum_next = {exp3_reg, {HalfW{1'b0}}} + zero_code_reg;
        end else if (same3_reg) begin
            if (man3_reg[OvfPos] == man3_reg[SignPos]) begin
                sum_next = {exp3_reg, man3_reg};
            end else begin
                sum_next = {exp3_reg + HalfW'(1), man_asr1};
            end
        end else begin
            sum_next = {exp3_reg - HalfW'(lead3_reg), man3_reg << lead3_reg};
        end
        sum_next = sum_next & ClearLsb;
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            sum4_reg <= sum_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_sum   = sum4_reg;

endmodule

// ===== src/cfan_checker.sv =====
// ----------------------------------------------------------------------------
// cfan_checker
// Port-level checks for the custom float adder, bound to the top level.
// ----------------------------------------------------------------------------
module cfan_checker
    import cfan_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [WordW-1:0] pwdata,
    input  logic [WordW-1:0] prdata,
    input  logic             pready,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [WordW-1:0] m_sum
);

    // hold a stalled result request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum))
        else $error("stalled result request changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_sum[0])
        else $error("result bit 0 set");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result request after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr[AddrW-1] == RegZeroCode)
        |=> (paddr[AddrW-1] != RegZeroCode) || (prdata == $past(pwdata)))
        else $error("zero_code readback mismatch");

    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind custom_float_adder_normalize_unit cfan_checker u_cfan_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_sum   (m_sum)
);

// ===== bench/custom_float_adder_normalize_unit_tb.sv =====
// ----------------------------------------------------------------------------
// custom_float_adder_normalize_unit_tb
// Drives operand pairs through the float adder with bursty valid and a
// stalling receiver, predicts every normalized sum in-bench and compares
// each result in order. Exercises the zero_code register over the APB port,
// with read-back, at reset value, extremes and random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module custom_float_adder_normalize_unit_tb
    import cfan_pkg::*;
;

    localparam int unsigned     ClkPeriod    = 20;
    localparam longint unsigned TimeoutNs    = 64'd10_000_000;
    localparam int unsigned     DrainCycles  = 8;
    localparam logic [WordW-1:0] ExpOne      = 32'h0001_0000;
    localparam logic [AddrW-1:0] ZeroCodeAddr = AddrW'(4 * RegZeroCode);

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             psel        = 1'b0;
    logic             penable     = 1'b0;
    logic             pwrite      = 1'b0;
    logic [AddrW-1:0] paddr       = '0;
    logic [WordW-1:0] pwdata      = '0;
    logic [WordW-1:0] prdata;
    logic             pready;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [WordW-1:0] s_operand_a = '0;
    logic [WordW-1:0] s_operand_b = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [WordW-1:0] m_sum;

    logic [WordW-1:0] pending_sums[$];
    logic [WordW-1:0] zero_code_shadow = '0;
    logic [WordW-1:0] oldest_sum;
    int unsigned      error_count = 0;
    int unsigned      burst_left  = 0;
    logic [1:0]       stall_mode  = '0;
    int unsigned      stall_count = 0;
    logic [15:0]      stall_mask  = '1;

    custom_float_adder_normalize_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum       (m_sum)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    function automatic logic [WordW-1:0] predict_sum(input logic [WordW-1:0] a,
                                                     input logic [WordW-1:0] b,
                                                     input logic [WordW-1:0] zc);
        logic [WordW-1:0] big;
        logic [WordW-1:0] lesser;
        logic [WordW-1:0] hi;
        logic [HalfW-1:0] gap;
        logic [HalfW-1:0] shifted;
        logic [HalfW-1:0] m;
        logic             same_sign;
        logic             neg;
        int unsigned      steps;
        big    = a;
        lesser = b;
        if ($signed(b) > $signed(a)) begin
            big    = b;
            lesser = a;
        end
        gap = big[31:16] - lesser[31:16];
        if (gap[SignPos] || gap > GapLimit)
            return big & ClearLsb;
        shifted   = HalfW'($signed(lesser[15:0]) >>> gap);
        m         = big[15:0] + shifted;
        hi        = {big[31:16], 16'h0000};
        same_sign = (a[SignPos] == b[SignPos]);
        neg       = m[SignPos];
        if (m == '0)
            return (hi + zc) & ClearLsb;
        if (same_sign) begin
            if (m[OvfPos] == neg)
                return (hi | {16'h0000, m}) & ClearLsb;
            m = HalfW'($signed(m) >>> 1);
            return ((hi + ExpOne) | {16'h0000, m}) & ClearLsb;
        end
        steps = 0;
        while (steps < MaxLeftSteps && m[NormPos] == neg) begin
            m     = m << 1;
            hi    = hi - ExpOne;
            steps = steps + 1;
        end
        return (hi | {16'h0000, m}) & ClearLsb;
    endfunction

    function automatic logic [HalfW-1:0] random_mantissa();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {4'b0001, 12'($urandom)};
            4, 5, 6:    return {4'b1110, 12'($urandom)};
            default:    return HalfW'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                   input logic [WordW-1:0] want);
        $display("[%0t] %s: got %08h, want %08h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic [WordW-1:0] a, input logic [WordW-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_valid     <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_sums.push_back(predict_sum(a, b, zero_code_shadow));
        burst_left--;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    task automatic write_zero_code(input logic [WordW-1:0] value);
        logic [WordW-1:0] readback;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ZeroCodeAddr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        zero_code_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
            report_mismatch("zero_code read-back", readback, value);
    endtask

    task automatic test_directed();
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h8000_0001);
        send_request(32'h5555_AAAA, 32'hAAAA_5555);
        send_request(32'h0000_1000, 32'h0000_1000);
        send_request(32'hFFFF_1800, 32'hFFFF_1800);
        send_request({16'h0010, 16'hD000}, {16'h0010, 16'hD000});
        send_request({16'h0010, 16'hF000}, {16'h0010, 16'hF000});
        send_request({16'h0003, 16'h7FFF}, {16'h0000, 16'h7FFF});
        send_request({16'h0020, 16'h1000}, {16'h0015, 16'h1FFF});
        send_request({16'h0020, 16'h1000}, {16'h0014, 16'h1FFF});
        send_request({16'h7000, 16'h1000}, {16'hF000, 16'h1000});
        send_request({16'h0020, 16'hF000}, {16'h001F, 16'h1000});
        send_request({16'h0005, 16'h1000}, {16'h0005, 16'hF001});
        send_request({16'h0005, 16'h1000}, {16'h0005, 16'hEFFF});
        send_request({16'h0000, 16'h7000}, {16'h0000, 16'hD000});
        send_request({16'h0003, 16'h8000}, {16'h0003, 16'h7FFF});
        send_request({16'h0009, 16'h1234}, {16'h0009, 16'hEDCC});
        send_request({16'h8000, 16'h0000}, {16'h8000, 16'h0000});
        send_request({16'h1234, 16'h8000}, {16'h1234, 16'h8000});
        send_request({16'h0000, 16'h0001}, {16'hFFFF, 16'hFFFF});
        send_request(32'h0003_1235, 32'h0003_1235);
    endtask

    task automatic test_zero_code();
        logic [WordW-1:0] codes[3];
        codes = '{32'hFFFF_FFFF, 32'h0001_0001, 32'h8000_0000};
        foreach (codes[i]) begin
            write_zero_code(codes[i]);
            send_request({16'hFFFF, 16'h1000}, {16'hFFFF, 16'hF000});
            send_request({16'h0007, 16'h0400}, {16'h0007, 16'hFC00});
            send_request({16'h0000, 16'h0000}, {16'h0000, 16'h0000});
        end
    endtask

    task automatic test_random(input int unsigned count);
        logic [HalfW-1:0] exp_a;
        logic [HalfW-1:0] exp_b;
        logic [HalfW-1:0] mant_a;
        logic [HalfW-1:0] mant_b;
        logic [HalfW-1:0] delta;
        int unsigned      pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick  = $urandom_range(0, 99);
            exp_a = HalfW'($urandom);
            if ($urandom_range(0, 3) == 0)
                exp_a = {exp_a[15], {15{exp_a[14]}}} ^ HalfW'($urandom_range(0, 3));
            delta  = HalfW'($urandom_range(0, 13));
            exp_b  = $urandom_range(0, 1) ? exp_a + delta : exp_a - delta;
            mant_a = random_mantissa();
            mant_b = random_mantissa();
            if (pick < 15) begin
                send_request($urandom, $urandom);
            end else if (pick < 35) begin
                mant_b = -mant_a + HalfW'($urandom_range(0, 6)) - 16'd3;
                exp_b  = exp_a + HalfW'($urandom_range(0, 2)) - 16'd1;
                send_request({exp_a, mant_a}, {exp_b, mant_b});
            end else begin
                send_request({exp_a, mant_a}, {exp_b, mant_b});
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_count == 0) begin
            stall_mode  <= 2'($urandom_range(0, 3));
            stall_count <= $urandom_range(16, 80);
            stall_mask  <= 16'($urandom);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= stall_mask[stall_count % 16];
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("unexpected result", m_sum, 'x);
            end else begin
                oldest_sum = pending_sums.pop_front();
                if (m_sum !== oldest_sum)
                    report_mismatch("sum", m_sum, oldest_sum);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_zero_code();
        write_zero_code($urandom);
        test_random(400);
        write_zero_code(32'h0000_0000);
        test_random(400);
        write_zero_code(32'hFFFF_FFFF);
        test_random(400);
        write_zero_code($urandom);
        test_random(400);
        wait_idle();
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0 && pending_sums.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
